// File: rtl/owrs_pkg.sv
package owrs_pkg;

  localparam int RomBits = 64;
  localparam int PosW = 7;
  localparam int IdxW = 6;
  localparam int CrcBits = 56;
  localparam logic [7:0] CrcPoly = 8'h8C;

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BIT = 2'd2;

  localparam logic [1:0] KIND_DIR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ACK = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_PRESENCE = 3'd1;
  localparam logic [2:0] ST_NO_DEVICE = 3'd2;
  localparam logic [2:0] ST_CRC_FAIL = 3'd3;
  localparam logic [2:0] ST_NO_MORE = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic presence;
    logic id_bit;
    logic comp_bit;
  } owrs_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic direction;
    logic [RomBits-1:0] rom_id;
    logic [2:0] status;
    logic last_device;
  } owrs_result_t;

  // one step of the reflected crc-8, lsb first
  function automatic logic [7:0] crc_step(logic [7:0] crc, logic din);
    logic [7:0] c;
    c = {1'b0, crc[7:1]};
    if (crc[0] ^ din) begin
      c = c ^ CrcPoly;
    end
    return c;
  endfunction

  // direction to request at zero-based position pos
  function automatic logic dir_for(logic [RomBits-1:0] rom, logic [PosW-1:0] ld,
                                   logic [IdxW-1:0] pos);
    logic [PosW-1:0] p;
    logic d;
    p = {1'b0, pos} + PosW'(1);
    if (p < ld) begin
      d = rom[pos];
    end else begin
      d = (p == ld);
    end
    return d;
  endfunction

endpackage

// File: rtl/owrs_core.sv
module owrs_core
  import owrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  owrs_item_t   item,
  output logic         has_res,
  output owrs_result_t res
);

  logic [RomBits-1:0] rom_bits, rom_bits_next;
  logic [PosW-1:0] last_discrepancy, last_discrepancy_next;
  logic last_device_seen, last_device_seen_next;
  logic [PosW-1:0] last_zero_pos, last_zero_pos_next;
  logic [PosW-1:0] bit_position, bit_position_next;
  logic searching, searching_next;
  logic [7:0] crc, crc_next;

  logic [IdxW-1:0] pos;
  logic taken;
  logic [PosW-1:0] new_pos;
  logic [PosW-1:0] lzp_new;
  logic [RomBits-1:0] rom_new;
  logic [7:0] crc_new;
  logic ldev_new;

  assign pos = bit_position[IdxW-1:0];
  assign new_pos = {1'b0, pos} + PosW'(1);
  assign taken = (item.id_bit != item.comp_bit) ? item.id_bit
               : dir_for(rom_bits, last_discrepancy, pos);
  assign lzp_new = (!item.id_bit && !item.comp_bit && !taken) ? new_pos : last_zero_pos;
  assign crc_new = (pos < IdxW'(CrcBits)) ? crc_step(crc, taken) : crc;
  assign ldev_new = last_device_seen | (lzp_new == '0);

  always_comb begin
    rom_new = rom_bits;
    rom_new[pos] = taken;
  end

  always_comb begin
    rom_bits_next = rom_bits;
    last_discrepancy_next = last_discrepancy;
    last_device_seen_next = last_device_seen;
    last_zero_pos_next = last_zero_pos;
    bit_position_next = bit_position;
    searching_next = searching;
    crc_next = crc;
    has_res = 1'b0;
    res = '0;
    unique case (item.opcode)
      OP_RESET: begin
        has_res = 1'b1;
        res.kind = KIND_ACK;
        rom_bits_next = '0;
        last_discrepancy_next = '0;
        last_device_seen_next = 1'b0;
        last_zero_pos_next = '0;
        bit_position_next = '0;
        searching_next = 1'b0;
      end
      OP_START: begin
        has_res = 1'b1;
        priority if (last_device_seen) begin
          searching_next = 1'b0;
          res.kind = KIND_DONE;
          res.status = ST_NO_MORE;
        end else if (!item.presence) begin
          rom_bits_next = '0;
          last_discrepancy_next = '0;
          last_device_seen_next = 1'b0;
          last_zero_pos_next = '0;
          bit_position_next = '0;
          searching_next = 1'b0;
          res.kind = KIND_DONE;
          res.status = ST_NO_PRESENCE;
        end else begin
          searching_next = 1'b1;
          bit_position_next = '0;
          last_zero_pos_next = '0;
          crc_next = '0;
          res.kind = KIND_DIR;
          res.direction = dir_for(rom_bits, last_discrepancy, '0);
        end
      end
      OP_BIT: begin
        if (searching) begin
          has_res = 1'b1;
          priority if (item.id_bit && item.comp_bit) begin
            searching_next = 1'b0;
            res.kind = KIND_DONE;
            res.status = ST_NO_DEVICE;
          end else if (new_pos < PosW'(RomBits)) begin
            rom_bits_next = rom_new;
            last_zero_pos_next = lzp_new;
            bit_position_next = new_pos;
            crc_next = crc_new;
            res.kind = KIND_DIR;
            res.direction = dir_for(rom_bits, last_discrepancy, new_pos[IdxW-1:0]);
          end else begin
            rom_bits_next = rom_new;
            last_zero_pos_next = lzp_new;
            bit_position_next = new_pos;
            searching_next = 1'b0;
            last_discrepancy_next = lzp_new;
            last_device_seen_next = ldev_new;
            res.kind = KIND_DONE;
            if (crc == rom_new[RomBits-1:CrcBits]) begin
              res.rom_id = rom_new;
              res.status = ST_OK;
              res.last_device = ldev_new;
            end else begin
              res.status = ST_CRC_FAIL;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bits <= '0;
      crc <= '0;
      last_discrepancy <= '0;
      last_device_seen <= 1'b0;
      last_zero_pos <= '0;
      bit_position <= '0;
      searching <= 1'b0;
    end else if (en) begin
      rom_bits <= rom_bits_next;
      crc <= crc_next;
      last_discrepancy <= last_discrepancy_next;
      last_device_seen <= last_device_seen_next;
      last_zero_pos <= last_zero_pos_next;
      bit_position <= bit_position_next;
      searching <= searching_next;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    searching |-> bit_position < PosW'(RomBits))
    else $error("bit position out of range during a pass");

  a_last_dev_no_disc: assert property (@(posedge clk) disable iff (rst)
    last_device_seen |-> last_discrepancy == '0)
    else $error("last device flagged with a discrepancy pending");

  a_pass_closes: assert property (@(posedge clk) disable iff (rst)
    (en && searching && item.opcode == OP_BIT && bit_position == PosW'(RomBits - 1))
      |=> !searching)
    else $error("pass still open after the final bit");

endmodule

// File: rtl/onewire_rom_search_engine.sv
// a request is held in the input register, its result in the result register
// throughput: one request per cycle; the input register moves on while the
// result register is free or being drained, so only a stalled result holds it
// reset: synchronous, active high; clears the search state, the discrepancy
// and last-device tracking, and empties both the input and result registers
module onewire_rom_search_engine
  import owrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic               presence,
  input  logic               id_bit,
  input  logic               comp_bit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic               direction,
  output logic [RomBits-1:0] rom_id,
  output logic [2:0]         status,
  output logic               last_device
);

  logic inq_valid;
  owrs_item_t inq;
  owrs_result_t res;
  owrs_result_t outq;
  logic has_res;
  logic out_free;
  logic en;

  assign out_free = !out_valid || !out_stall;
  assign en = inq_valid && (!has_res || out_free);
  assign in_stall = inq_valid && !en;

  owrs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .item    (inq),
    .has_res (has_res),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      inq <= '{opcode: opcode, presence: presence, id_bit: id_bit, comp_bit: comp_bit};
    end
    if (en && has_res) begin
      outq <= res;
    end
    if (rst) begin
      inq_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        inq_valid <= in_valid;
      end
      if (en && has_res) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign kind = outq.kind;
  assign direction = outq.direction;
  assign rom_id = outq.rom_id;
  assign status = outq.status;
  assign last_device = outq.last_device;

endmodule
